FILE: rtl/lct_pkg.sv
package lct_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CMD_W         = 2;
  localparam int KEY_W         = 16;
  localparam int VALUE_W       = 32;

  localparam logic [VALUE_W-1:0] MISS_WORD = 32'hBF80_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: rtl/lru_cache_table.sv
// lru_cache_table: fully associative cache of DEPTH entries in recency order.
// requests enter on in_valid/in_ready with command, key and value; each
// request gives exactly one result on out_valid/out_ready (hit, read_data).
// lookup: hit returns the data word and moves the entry to the front; a miss
// returns 0xBF800000. insert pushes onto the front, dropping the oldest entry
// when full. clear removes the first matching entry and closes the gap.
// entries live in a single-port-read, single-port-write ram with a registered
// read; a request walks the ram one entry per cycle:
//   lookup hit at position j: scan up to j, then shift the entries ahead of
//     it up one place when j > 0, one head write and one result step
//   lookup miss / clear miss with n valid entries: scan all n, then result
//   insert: shift entries up one place (oldest drops when full), head write,
//     result; only head write and result when empty
//   clear hit at j: scan, shift later entries down unless j is n - 1, result
// the next request is taken once the previous one has reached the output
// register, so a stalled receiver holds at most one result while the block
// accepts one more request; the block then waits until the result drains.
// reset empties the table at once (fill count cleared) and drops any result.
module lru_cache_table #(
  parameter int DEPTH = lct_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lct_pkg::CMD_W-1:0]   command,
  input  logic [lct_pkg::KEY_W-1:0]   key,
  input  logic [lct_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [lct_pkg::VALUE_W-1:0] read_data
);
  import lct_pkg::*;

  localparam int IW = addr_w(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_HEAD,
    S_RESP
  } state_t;

  state_t               state;
  logic                 op_lookup;
  logic [KEY_W-1:0]     key_q;
  logic [VALUE_W-1:0]   val_q;
  logic [CW-1:0]        count;
  logic [IW-1:0]        issue_addr;
  logic                 issuing;
  logic                 rd_ok;
  logic [IW-1:0]        rd_pos;
  logic [VALUE_W-1:0]   found_data;
  logic                 hit_res;
  logic [VALUE_W-1:0]   data_res;

  logic                 ram_rd_en;
  logic                 ram_wr_en;
  logic [IW-1:0]        ram_wr_addr;
  entry_t               ram_wr_data;
  entry_t               rd_entry;
  logic                 rd_match;
  logic                 rd_last;
  logic                 issue_last;
  logic [CW-1:0]        fill_top;

  lct_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .rd_en  (ram_rd_en),
    .rd_addr(issue_addr),
    .rd_data(rd_entry),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data)
  );

  assign in_ready   = (state == S_IDLE);
  assign rd_match   = (rd_entry.key == key_q);
  assign rd_last    = ((CW'(rd_pos) + CW'(1)) == count);
  assign issue_last = ((CW'(issue_addr) + CW'(1)) == count);
  assign fill_top   = (count == FULL) ? (FULL - CW'(1)) : count;

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = rd_entry;
    unique case (state)
      S_SCAN: begin
        ram_rd_en = issuing && !(rd_ok && rd_match);
      end
      S_SHIFT_UP: begin
        ram_rd_en   = issuing;
        ram_wr_en   = rd_ok;
        ram_wr_addr = rd_pos + IW'(1);
      end
      S_SHIFT_DN: begin
        ram_rd_en   = issuing;
        ram_wr_en   = rd_ok;
        ram_wr_addr = rd_pos - IW'(1);
      end
      S_HEAD: begin
        ram_wr_en         = 1'b1;
        ram_wr_addr       = '0;
        ram_wr_data.key   = key_q;
        ram_wr_data.value = op_lookup ? found_data : val_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issuing   <= 1'b0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_ok  <= ram_rd_en;
      rd_pos <= issue_addr;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_q     <= key;
            val_q     <= value;
            op_lookup <= (command == CMD_LOOKUP);
            unique case (command)
              CMD_LOOKUP, CMD_CLEAR: begin
                if (count == '0) begin
                  hit_res  <= 1'b0;
                  data_res <= (command == CMD_LOOKUP) ? MISS_WORD : '0;
                  state    <= S_RESP;
                end else begin
                  issue_addr <= '0;
                  issuing    <= 1'b1;
                  state      <= S_SCAN;
                end
              end
              CMD_INSERT: begin
                if (fill_top == '0) begin
                  state <= S_HEAD;
                end else begin
                  issue_addr <= IW'(fill_top - CW'(1));
                  issuing    <= 1'b1;
                  state      <= S_SHIFT_UP;
                end
              end
              default: begin
                hit_res  <= 1'b0;
                data_res <= '0;
                state    <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            if (issue_last) begin
              issuing <= 1'b0;
            end else begin
              issue_addr <= issue_addr + IW'(1);
            end
          end
          if (rd_ok) begin
            if (rd_match) begin
              issuing <= 1'b0;
              if (op_lookup) begin
                found_data <= rd_entry.value;
                if (rd_pos == '0) begin
                  state <= S_HEAD;
                end else begin
                  issue_addr <= rd_pos - IW'(1);
                  issuing    <= 1'b1;
                  state      <= S_SHIFT_UP;
                end
              end else if (rd_last) begin
                count    <= count - CW'(1);
                hit_res  <= 1'b0;
                data_res <= '0;
                state    <= S_RESP;
              end else begin
                issue_addr <= rd_pos + IW'(1);
                issuing    <= 1'b1;
                state      <= S_SHIFT_DN;
              end
            end else if (rd_last) begin
              hit_res  <= 1'b0;
              data_res <= op_lookup ? MISS_WORD : '0;
              state    <= S_RESP;
            end
          end
        end
        S_SHIFT_UP: begin
          if (issuing) begin
            if (issue_addr == '0) begin
              issuing <= 1'b0;
            end else begin
              issue_addr <= issue_addr - IW'(1);
            end
          end
          if (rd_ok && (rd_pos == '0)) begin
            state <= S_HEAD;
          end
        end
        S_SHIFT_DN: begin
          if (issuing) begin
            if (issue_last) begin
              issuing <= 1'b0;
            end else begin
              issue_addr <= issue_addr + IW'(1);
            end
          end
          if (rd_ok && rd_last) begin
            count    <= count - CW'(1);
            hit_res  <= 1'b0;
            data_res <= '0;
            state    <= S_RESP;
          end
        end
        S_HEAD: begin
          if (!op_lookup && (count != FULL)) begin
            count <= count + CW'(1);
          end
          hit_res  <= op_lookup;
          data_res <= op_lookup ? found_data : '0;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= hit_res;
            read_data <= data_res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lct_ram.sv
module lct_ram #(
  parameter int DEPTH = lct_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [lct_pkg::addr_w(DEPTH)-1:0] rd_addr,
  output lct_pkg::entry_t                   rd_data,
  input  logic                              wr_en,
  input  logic [lct_pkg::addr_w(DEPTH)-1:0] wr_addr,
  input  lct_pkg::entry_t                   wr_data
);
  import lct_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: verif/lru_cache_table_checker.sv
`timescale 1ns / 1ps
module lru_cache_table_checker #(
  parameter int DEPTH = lct_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [lct_pkg::CMD_W-1:0]   command,
  input  logic [lct_pkg::KEY_W-1:0]   key,
  input  logic [lct_pkg::VALUE_W-1:0] value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        hit,
  input  logic [lct_pkg::VALUE_W-1:0] read_data,
  output int                          failures,
  output int                          open_replies,
  output int                          checked_total,
  output int                          hit_total,
  output int                          miss_total,
  output int                          evict_total
);

  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic                        found;
    logic [lct_pkg::VALUE_W-1:0] word;
  } reply_t;

  // recency-ordered shadow of the cache, valid entries packed at the front
  lct_pkg::entry_t slots[DEPTH];
  int              fill;
  reply_t          replies_due[$];

  int errors  = 0;
  int checked = 0;
  int hits_n  = 0;
  int misses_n = 0;
  int evicts_n = 0;

  initial begin
    failures      = 0;
    open_replies  = 0;
    checked_total = 0;
    hit_total     = 0;
    miss_total    = 0;
    evict_total   = 0;
    fill          = 0;
  end

  task automatic apply_request(input logic [lct_pkg::CMD_W-1:0] cmd,
                               input logic [lct_pkg::KEY_W-1:0] k,
                               input logic [lct_pkg::VALUE_W-1:0] v,
                               output reply_t r);
    int              pos;
    lct_pkg::entry_t moved;
    pos = -1;
    r   = '0;
    for (int j = 0; j < fill; j++) begin
      if (pos < 0 && slots[j].key == k) pos = j;
    end
    case (cmd)
      lct_pkg::CMD_LOOKUP: begin
        if (pos >= 0) begin
          moved = slots[pos];
          for (int j = pos; j > 0; j--) slots[j] = slots[j-1];
          slots[0] = moved;
          r.found  = 1'b1;
          r.word   = moved.value;
          hits_n++;
        end else begin
          r.word = lct_pkg::MISS_WORD;
          misses_n++;
        end
      end
      lct_pkg::CMD_INSERT: begin
        if (fill == DEPTH) evicts_n++;
        else fill++;
        for (int j = fill - 1; j > 0; j--) slots[j] = slots[j-1];
        slots[0].key   = k;
        slots[0].value = v;
      end
      lct_pkg::CMD_CLEAR: begin
        if (pos >= 0) begin
          for (int j = pos; j < fill - 1; j++) slots[j] = slots[j+1];
          fill--;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    if (rst) begin
      fill = 0;
      replies_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        apply_request(command, key, value, want);
        replies_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.found = hit;
        got.word  = read_data;
        checked++;
        if (replies_due.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected result hit=%0b read_data=%h", $time, got.found,
                     got.word);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (got.found !== want.found) begin
            if (errors < MAX_REPORTS)
              $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.found,
                       got.found);
            errors++;
          end
          if (got.word !== want.word) begin
            if (errors < MAX_REPORTS)
              $display("%0t: read_data mismatch, expected %h, actual %h", $time,
                       want.word, got.word);
            errors++;
          end
        end
      end
    end
    failures      <= errors;
    open_replies  <= replies_due.size();
    checked_total <= checked;
    hit_total     <= hits_n;
    miss_total    <= misses_n;
    evict_total   <= evicts_n;
  end

endmodule

FILE: verif/lru_cache_table_tb.sv
`timescale 1ns / 1ps
module lru_cache_table_tb;

  localparam int DEPTH        = lct_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1600;
  localparam int POOL_SIZE    = 32;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

  localparam logic [lct_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_CHOPPY
  } sink_mode_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_EVEN,
    MIX_DRAIN
  } mix_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [lct_pkg::CMD_W-1:0]   command   = '0;
  logic [lct_pkg::KEY_W-1:0]   key       = '0;
  logic [lct_pkg::VALUE_W-1:0] value     = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        hit;
  logic [lct_pkg::VALUE_W-1:0] read_data;

  int failures;
  int open_replies;
  int checked_total;
  int hit_total;
  int miss_total;
  int evict_total;

  int         cycle_count = 0;
  int         request_count = 0;
  sink_mode_t sink_mode = SINK_OPEN;
  int         mode_left = 0;
  int         run_left  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  lru_cache_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .key      (key),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit      (hit),
    .read_data(read_data)
  );

  lru_cache_table_checker #(
    .DEPTH(DEPTH)
  ) watch (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .key          (key),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .read_data    (read_data),
    .failures     (failures),
    .open_replies (open_replies),
    .checked_total(checked_total),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .evict_total  (evict_total)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               open_replies);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure, switching between free, coin-flip and long stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mode_left <= 0;
      run_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(2, 0));
        mode_left <= $urandom_range(600, 100);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN: out_ready <= 1'b1;
        SINK_COIN: out_ready <= ($urandom_range(9, 0) < 6);
        default: begin
          if (run_left == 0) begin
            out_ready <= ~out_ready;
            run_left  <= out_ready ? $urandom_range(30, 1) : $urandom_range(8, 1);
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  task automatic send_request(input logic [lct_pkg::CMD_W-1:0] c,
                              input logic [lct_pkg::KEY_W-1:0] k,
                              input logic [lct_pkg::VALUE_W-1:0] v);
    in_valid <= 1'b1;
    command  <= c;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    request_count++;
  endtask

  initial begin : stimulus
    logic [lct_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
    logic [lct_pkg::KEY_W-1:0] k;
    logic [lct_pkg::CMD_W-1:0] c;
    mix_t                      mix;
    int                        key_span;
    int                        ins_pct;
    int                        clr_pct;
    int                        phase_left;
    int                        sent;
    int                        burst;
    int                        gap;
    int                        roll;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, unused command, extreme keys and data
    send_request(lct_pkg::CMD_LOOKUP, 16'h1234, $urandom);
    send_request(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(lct_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_request(lct_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(lct_pkg::CMD_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    // duplicate key, then clear the newer copy
    send_request(lct_pkg::CMD_INSERT, 16'hFFFF, 32'h1234_5678);
    send_request(lct_pkg::CMD_LOOKUP, 16'hFFFF, '0);
    send_request(lct_pkg::CMD_CLEAR, 16'hFFFF, '0);
    send_request(lct_pkg::CMD_LOOKUP, 16'hFFFF, '0);
    send_request(lct_pkg::CMD_CLEAR, 16'h5555, '0);
    // overfill so the oldest entry drops
    for (int i = 0; i < DEPTH - 1; i++)
      send_request(lct_pkg::CMD_INSERT, 16'h0100 + i[15:0], $urandom);
    send_request(lct_pkg::CMD_LOOKUP, 16'h0000, '0);
    send_request(lct_pkg::CMD_LOOKUP, 16'h0100, '0);

    sent       = 0;
    phase_left = 0;
    key_span   = POOL_SIZE;
    ins_pct    = 30;
    clr_pct    = 20;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        mix        = mix_t'($urandom_range(2, 0));
        key_span   = ($urandom_range(1, 0) == 1) ? 8 : POOL_SIZE;
        phase_left = $urandom_range(200, 60);
        case (mix)
          MIX_FILL: begin
            ins_pct = 60;
            clr_pct = 5;
          end
          MIX_EVEN: begin
            ins_pct = 30;
            clr_pct = 20;
          end
          default: begin
            ins_pct = 15;
            clr_pct = 45;
          end
        endcase
      end
      burst = $urandom_range(24, 1);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        roll = $urandom_range(99, 0);
        if (roll < 5) c = CMD_UNUSED;
        else if (roll < 5 + ins_pct) c = lct_pkg::CMD_INSERT;
        else if (roll < 5 + ins_pct + clr_pct) c = lct_pkg::CMD_CLEAR;
        else c = lct_pkg::CMD_LOOKUP;
        if ($urandom_range(15, 0) == 0) k = 16'($urandom);
        else k = key_pool[$urandom_range(key_span - 1, 0)];
        send_request(c, k, $urandom);
        sent++;
        phase_left--;
      end
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (open_replies != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests over %0d cycles; %0d results checked", request_count,
             cycle_count, checked_total);
    $display("lookups hit %0d times, missed %0d times; %0d entries evicted by inserts",
             hit_total, miss_total, evict_total);
    if (failures == 0 && open_replies == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", failures, open_replies);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: lru_cache_table.f
rtl/lct_pkg.sv
rtl/lct_ram.sv
rtl/lru_cache_table.sv
verif/lru_cache_table_checker.sv
verif/lru_cache_table_tb.sv
